@@ hw/rtl/bitplane_to_chunky_pixels_macros.svh @@
// Assertion macros for the bitplane to chunky pixel converter.
// Used by the queue, front end and back end; no other dependencies.
`ifndef BITPLANE_TO_CHUNKY_PIXELS_MACROS_SVH
`define BITPLANE_TO_CHUNKY_PIXELS_MACROS_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle
`define BPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent in the next cycle
`define BPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/bpc_pkg.sv @@
// Shared types, constants and command codes for the bitplane to chunky converter.
// No dependencies.
`default_nettype none

package bpc_pkg;

  // Fixed geometry
  localparam int MAX_PLANES    = 4;
  localparam int LOWER_N       = MAX_PLANES - 1;
  localparam int PW            = 16;
  localparam int PIX_W         = MAX_PLANES;
  localparam int PC_W          = 2;
  localparam int NP_W          = 3;
  localparam int WPL_W         = 6;
  localparam int MAX_WORDS_DEF = 40;
  localparam int QUEUE_DEPTH   = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORDS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT      = 2'd2;

  localparam logic [NP_W-1:0]  PLANE_COUNT_RST = 3'd4;
  localparam logic [WPL_W-1:0] WORDS_RST       = 6'd20;
  localparam logic             LAYOUT_RST      = 1'b0;

  // Back-end command codes
  localparam logic [1:0] OP_HOLD    = 2'd0;
  localparam logic [1:0] OP_STORE   = 2'd1;
  localparam logic [1:0] OP_EMIT_IL = 2'd2;
  localparam logic [1:0] OP_EMIT_LS = 2'd3;

  typedef struct packed {
    logic [1:0]      op;
    logic [PC_W-1:0] pc;
    logic            lol;
  } cmd_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/bpc_if.sv @@
// Channel interfaces: plane word input, pixel output and configuration write.
// Depends on bpc_pkg.
`default_nettype none

interface bpc_in_if;
  import bpc_pkg::*;
  logic          valid;
  logic          ready;
  logic [PW-1:0] plane_word;
  modport source (output valid, output plane_word, input ready);
  modport sink (input valid, input plane_word, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_index;
  logic             group_last;
  logic             line_end;
  modport source (output valid, output pixel_index, output group_last,
                  output line_end, input ready);
  modport sink (input valid, input pixel_index, input group_last,
                input line_end, output ready);
endinterface

interface bpc_cfg_if;
  import bpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bpc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/bpc_queue.sv @@
// Small command queue between front and back end.
// Uses the assertion macros header.
`default_nettype none
`include "bitplane_to_chunky_pixels_macros.svh"

module bpc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_pop,
  output logic [W-1:0] rd_data
);

  logic [W-1:0]  ent_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = ent_r[rp_r];
  assign push     = wr_valid && wr_ready;

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (rd_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    case ({push, rd_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold the entry payload
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wr_data;
    end
  end

  `BPC_ASSERT_IMP(a_q_no_underflow, clk, rst_n, rd_pop, cnt_r != '0, "pop from empty queue")

endmodule

`default_nettype wire

@@ hw/rtl/bpc_front.sv @@
// Front end: configuration registers, plane and word counters, item classification.
// Depends on bpc_pkg, bpc_if and the assertion macros header.
`default_nettype none
`include "bitplane_to_chunky_pixels_macros.svh"

module bpc_front #(
  parameter int MAX_WORDS = bpc_pkg::MAX_WORDS_DEF,
  localparam int WC_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bpc_in_if.sink                in_ch,
  bpc_cfg_if.sink               cfg_ch,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output bpc_pkg::cmd_ctl_t     cmd_ctl,
  output logic [WC_W-1:0]       cmd_wc,
  output logic [bpc_pkg::PW-1:0] cmd_word
);
  import bpc_pkg::*;

  localparam int NW_W = $clog2(MAX_WORDS + 1);
  localparam int CW   = WPL_W + 1;

  logic [NP_W-1:0]  plane_count_r;
  logic [WPL_W-1:0] words_r;
  logic             layout_r;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [WC_W-1:0]  wc_r, wc_nxt;

  logic [NP_W-1:0]  np;
  logic [NW_W-1:0]  nw;
  logic [PC_W-1:0]  pc_use;
  logic [WC_W-1:0]  wc_use;
  logic             last_plane;
  logic             lol;
  logic             in_fire;
  cmd_ctl_t         ctl_c;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = cmd_ready;
  assign cmd_valid    = in_ch.valid;
  assign in_fire      = in_ch.valid && cmd_ready;

  // Clamp register values to the supported range
  always_comb begin
    if (plane_count_r == '0) begin
      np = NP_W'(1);
    end else if (plane_count_r > NP_W'(MAX_PLANES)) begin
      np = NP_W'(MAX_PLANES);
    end else begin
      np = plane_count_r;
    end
    if (words_r == '0) begin
      nw = NW_W'(1);
    end else if (CW'(words_r) > CW'(MAX_WORDS)) begin
      nw = NW_W'(MAX_WORDS);
    end else begin
      nw = NW_W'(words_r);
    end
  end

  // Restart counters that lie beyond their limit, then classify the beat
  always_comb begin
    pc_use     = (NP_W'(pc_r) >= np) ? '0 : pc_r;
    wc_use     = (NW_W'(wc_r) >= nw) ? '0 : wc_r;
    last_plane = ((NP_W'(pc_use) + NP_W'(1)) == np);
    lol        = ((NW_W'(wc_use) + NW_W'(1)) == nw);
    ctl_c.pc   = pc_use;
    ctl_c.lol  = lol;
    pc_nxt     = pc_use;
    wc_nxt     = wc_use;
    if (!layout_r) begin
      if (!last_plane) begin
        ctl_c.op = OP_HOLD;
        pc_nxt   = pc_use + PC_W'(1);
      end else begin
        ctl_c.op = OP_EMIT_IL;
        pc_nxt   = '0;
        wc_nxt   = lol ? '0 : wc_use + WC_W'(1);
      end
    end else begin
      if (!last_plane) begin
        ctl_c.op = OP_STORE;
        if (lol) begin
          pc_nxt = pc_use + PC_W'(1);
        end
      end else begin
        ctl_c.op = OP_EMIT_LS;
        if (lol) begin
          pc_nxt = '0;
        end
      end
      wc_nxt = lol ? '0 : wc_use + WC_W'(1);
    end
  end

  assign cmd_ctl  = ctl_c;
  assign cmd_wc   = wc_use;
  assign cmd_word = in_ch.plane_word;

  // Configuration writes and counter update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_count_r <= PLANE_COUNT_RST;
      words_r       <= WORDS_RST;
      layout_r      <= LAYOUT_RST;
      pc_r          <= '0;
      wc_r          <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_PLANE_COUNT: plane_count_r <= cfg_ch.data[NP_W-1:0];
          REG_WORDS:       words_r       <= cfg_ch.data[WPL_W-1:0];
          REG_LAYOUT:      layout_r      <= cfg_ch.data[0];
          default:         ;
        endcase
      end
      if (in_fire) begin
        pc_r <= pc_nxt;
        wc_r <= wc_nxt;
      end
    end
  end

  `BPC_ASSERT_NXT(a_fe_il_restart, clk, rst_n, in_fire && (ctl_c.op == OP_EMIT_IL), pc_r == '0, "plane count not restarted after interleaved group")

endmodule

`default_nettype wire

@@ hw/rtl/bpc_back.sv @@
// Back end: held plane words, line store, pixel serialiser and output register.
// Depends on bpc_pkg, bpc_if, bpc_ram and the assertion macros header.
`default_nettype none
`include "bitplane_to_chunky_pixels_macros.svh"

module bpc_back #(
  parameter int MAX_WORDS = bpc_pkg::MAX_WORDS_DEF,
  localparam int WC_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  output logic                   cmd_pop,
  input  bpc_pkg::cmd_ctl_t      cmd_ctl,
  input  logic [WC_W-1:0]        cmd_wc,
  input  logic [bpc_pkg::PW-1:0] cmd_word,
  bpc_out_if.source              out_ch
);
  import bpc_pkg::*;

  localparam int LW    = PW * LOWER_N;
  localparam int CNT_W = $clog2(PW);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PW - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_gl_r;
  logic             out_le_r;
  logic [CNT_W-1:0] cnt_r;

  logic [1:0]       cur_op_r;
  logic [PC_W-1:0]  cur_pc_r;
  logic             cur_lol_r;
  logic [WC_W-1:0]  cur_wc_r;
  logic [PW-1:0]    cur_word_r;

  logic [PW-1:0]    held_r [LOWER_N];
  logic [PW-1:0]    sh_r [MAX_PLANES];

  logic [PW-1:0]    ld_src [MAX_PLANES];
  logic [PW-1:0]    ld_plane [MAX_PLANES];
  logic [PC_W-1:0]  ld_pc;
  logic [PW-1:0]    ld_word;
  logic [LW-1:0]    row_new;
  logic [PIX_W-1:0] pix_c;

  logic             px_fire;
  logic             load_il, load_ls, load;
  logic             needs_rd, store0, hold;
  logic             ram_we, ram_re;
  logic [WC_W-1:0]  ram_waddr;
  logic [LW-1:0]    ram_wdata, ram_rdata;

  // Line store: one row per word position, one 16-bit field per lower plane
  bpc_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WORDS)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cmd_wc),
    .rdata (ram_rdata)
  );

  assign ld_pc   = (state_r == ST_IDLE) ? cmd_ctl.pc : cur_pc_r;
  assign ld_word = (state_r == ST_IDLE) ? cmd_word : cur_word_r;

  // Build plane words for the serialiser, and the merged store row
  for (genvar k = 0; k < MAX_PLANES; k++) begin : g_plane
    if (k < LOWER_N) begin : g_low
      assign ld_src[k] = (state_r == ST_IDLE) ? held_r[k] : ram_rdata[k*PW +: PW];
      assign row_new[k*PW +: PW] = (PC_W'(k) == cur_pc_r) ? cur_word_r
                                                          : ram_rdata[k*PW +: PW];
    end else begin : g_top
      assign ld_src[k] = '0;
    end
    assign ld_plane[k] = (PC_W'(k) < ld_pc)  ? ld_src[k] :
                         (PC_W'(k) == ld_pc) ? ld_word   : '0;
    assign pix_c[k]    = sh_r[k][PW-1];
  end

  // Decode the popped command
  always_comb begin
    cmd_pop  = (state_r == ST_IDLE) && cmd_valid;
    px_fire  = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
    hold     = cmd_pop && (cmd_ctl.op == OP_HOLD);
    store0   = cmd_pop && (cmd_ctl.op == OP_STORE) && (cmd_ctl.pc == '0);
    needs_rd = cmd_pop && (cmd_ctl.pc != '0) &&
               ((cmd_ctl.op == OP_STORE) || (cmd_ctl.op == OP_EMIT_LS));
    load_il  = cmd_pop && ((cmd_ctl.op == OP_EMIT_IL) ||
                           ((cmd_ctl.op == OP_EMIT_LS) && (cmd_ctl.pc == '0)));
    load_ls  = (state_r == ST_READ) && (cur_op_r == OP_EMIT_LS);
    load     = load_il || load_ls;
    ram_re   = needs_rd;
    ram_we   = store0 || ((state_r == ST_READ) && (cur_op_r == OP_STORE));
    ram_waddr = store0 ? cmd_wc : cur_wc_r;
    ram_wdata = store0 ? LW'(cmd_word) : row_new;
  end

  // Sequence the back end
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (load_il) begin
          state_nxt = ST_EMIT;
        end else if (needs_rd) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = load_ls ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (px_fire && (cnt_r == CNT_MAX)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = px_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (load) begin
        cnt_r <= '0;
      end else if (px_fire) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // Hold the command, held words, plane shifters and output beat
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_op_r   <= cmd_ctl.op;
      cur_pc_r   <= cmd_ctl.pc;
      cur_lol_r  <= cmd_ctl.lol;
      cur_wc_r   <= cmd_wc;
      cur_word_r <= cmd_word;
    end
    if (hold) begin
      held_r[cmd_ctl.pc] <= cmd_word;
    end
    for (int k = 0; k < MAX_PLANES; k++) begin
      if (load) begin
        sh_r[k] <= ld_plane[k];
      end else if (px_fire) begin
        sh_r[k] <= {sh_r[k][PW-2:0], 1'b0};
      end
    end
    if (px_fire) begin
      out_pix_r <= pix_c;
      out_gl_r  <= (cnt_r == CNT_MAX);
      out_le_r  <= (cnt_r == CNT_MAX) && cur_lol_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_index = out_pix_r;
  assign out_ch.group_last  = out_gl_r;
  assign out_ch.line_end    = out_le_r;

  `BPC_ASSERT_NXT(a_be_group_done, clk, rst_n, px_fire && (cnt_r == CNT_MAX), state_r == ST_IDLE, "back end not idle after sixteenth pixel")
  `BPC_ASSERT_NXT(a_be_read_once, clk, rst_n, state_r == ST_READ, state_r != ST_READ, "line store read held longer than one cycle")
  `BPC_ASSERT_IMP(a_be_line_end_last, clk, rst_n, out_valid_r && out_le_r, out_gl_r, "line end away from last pixel of group")

endmodule

`default_nettype wire

@@ hw/rtl/bitplane_to_chunky_pixels.sv @@
// An emitting word's beat passes the queue, a line-store read when lower planes come
// from the line store, the plane shifters and the output register, then one pixel
// a cycle while the output is not stalled. No command is popped until all 16 pixels are
// out; held and first-plane store words finish at the pop, higher store planes add a read.
// Reset: registers to 4 planes, 20 words, interleaved; counters cleared. Line store and
// held words are not cleared.
`default_nettype none

module bitplane_to_chunky_pixels #(
  parameter int MAX_WORDS_PER_PLANE = bpc_pkg::MAX_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bpc_in_if.sink    in_ch,
  bpc_out_if.source out_ch,
  bpc_cfg_if.sink   cfg_ch
);
  import bpc_pkg::*;

  localparam int WC_W = (MAX_WORDS_PER_PLANE > 1) ? $clog2(MAX_WORDS_PER_PLANE) : 1;
  localparam int QW   = $bits(cmd_ctl_t) + WC_W + PW;

  cmd_ctl_t        f_ctl, q_ctl;
  logic [WC_W-1:0] f_wc, q_wc;
  logic [PW-1:0]   f_word, q_word;
  logic            f_valid, f_ready;
  logic            q_valid, q_pop;
  logic [QW-1:0]   q_data;

  // Accept and classify plane words
  bpc_front #(
    .MAX_WORDS (MAX_WORDS_PER_PLANE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_ctl   (f_ctl),
    .cmd_wc    (f_wc),
    .cmd_word  (f_word)
  );

  // Decouple front and back end
  bpc_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_ctl, f_wc, f_word}),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_data)
  );

  assign {q_ctl, q_wc, q_word} = q_data;

  // Carry out commands and serialise pixels
  bpc_back #(
    .MAX_WORDS (MAX_WORDS_PER_PLANE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd_ctl   (q_ctl),
    .cmd_wc    (q_wc),
    .cmd_word  (q_word),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
